[hdl/type_descriptor_parser_defines.svh]
// Assertion macros used by the checker file of the descriptor parser.
`ifndef TYPE_DESCRIPTOR_PARSER_DEFINES_SVH
`define TYPE_DESCRIPTOR_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/tdp_pkg.sv]
`default_nettype none

package tdp_pkg;

   localparam int MAX_DIGITS  = 4;
   localparam int MAX_RECORDS = 256;

   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 14;
   localparam int CODE_W  = 3;
   localparam int FLAG_W  = 2;
   localparam int INDEX_W = 8;
   localparam int DIGIT_W = 3;
   localparam int REC_W   = 9;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [FLAG_W-1:0]  flag_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [DIGIT_W-1:0] digit_count_type;
   typedef logic [REC_W-1:0]   rec_count_type;

   // Type codes shared by key and value.
   localparam code_type CODE_NONE = 3'd0;
   localparam code_type CODE_I    = 3'd1;
   localparam code_type CODE_U    = 3'd2;
   localparam code_type CODE_D    = 3'd3;
   localparam code_type CODE_P    = 3'd4;
   localparam code_type CODE_S    = 3'd5;
   localparam code_type CODE_A    = 3'd6;

   localparam flag_type FLAG_NONE = 2'd0;
   localparam flag_type FLAG_R    = 2'd1;
   localparam flag_type FLAG_D    = 2'd2;

   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_NINE  = 8'h39;
   localparam char_type CH_COLON = 8'h3A;
   localparam char_type CH_BAR   = 8'h7C;
   localparam char_type CH_UP_R  = 8'h52;
   localparam char_type CH_UP_D  = 8'h44;
   localparam char_type CH_LO_I  = 8'h69;
   localparam char_type CH_LO_U  = 8'h75;
   localparam char_type CH_LO_D  = 8'h64;
   localparam char_type CH_LO_P  = 8'h70;
   localparam char_type CH_LO_S  = 8'h73;
   localparam char_type CH_LO_A  = 8'h61;

   typedef struct packed {
      logic      record_valid;
      logic      parse_error;
      index_type record_index;
      count_type repeat_count;
      code_type  key_code;
      code_type  value_code;
      flag_type  flag_code;
      logic      string_done;
   } rsp_payload_type;

   function automatic code_type letter_code(input char_type c);
      code_type code;
      case (c)
         CH_LO_I: code = CODE_I;
         CH_LO_U: code = CODE_U;
         CH_LO_D: code = CODE_D;
         CH_LO_P: code = CODE_P;
         CH_LO_S: code = CODE_S;
         CH_LO_A: code = CODE_A;
         default: code = CODE_NONE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[hdl/tdp_channels.sv]
`default_nettype none

interface tdp_req_if import tdp_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type char_in;
   logic     last_char;

   modport source (output valid, output char_in, output last_char, input ready);
   modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface tdp_rsp_if import tdp_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      record_valid;
   logic      parse_error;
   index_type record_index;
   count_type repeat_count;
   code_type  key_code;
   code_type  value_code;
   flag_type  flag_code;
   logic      string_done;

   modport source (output valid, output record_valid, output parse_error,
                   output record_index, output repeat_count, output key_code,
                   output value_code, output flag_code, output string_done,
                   input ready);
   modport sink   (input valid, input record_valid, input parse_error,
                   input record_index, input repeat_count, input key_code,
                   input value_code, input flag_code, input string_done,
                   output ready);
endinterface

interface tdp_csr_if import tdp_pkg::*; ();
   logic valid;
   logic ready;
   logic key_value_mode;

   modport source (output valid, output key_value_mode, input ready);
   modport sink   (input valid, input key_value_mode, output ready);
endinterface

`default_nettype wire

[hdl/type_descriptor_parser.sv]
// A result beat is registered and appears in the cycle after its input beat is accepted.
// One character per cycle unless a result beat is stalled; the parse state
// updates in one pass and the result register frees itself whenever its beat is taken.
// Reset (synchronous, active high) clears the parse state and the result
// valid, and sets key_value_mode to 1.
`default_nettype none

module type_descriptor_parser import tdp_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   tdp_req_if.sink       req_chan,
   tdp_rsp_if.source     rsp_chan,
   tdp_csr_if.sink       csr_chan
);

   logic            kv_mode_ff;
   code_type        key_ff, key_in;
   code_type        value_ff, value_in;
   flag_type        flag_ff, flag_in;
   count_type       count_ff, count_in;
   digit_count_type digits_ff, digits_in;
   logic            colon_ff, colon_in;
   logic            error_ff, error_in;
   rec_count_type   records_ff, records_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic            accept;
   char_type        c;
   code_type        lc;
   logic            is_digit;
   char_type        digit_diff;
   logic            err;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign c          = req_chan.char_in;
   assign lc         = letter_code(c);
   assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
   assign digit_diff = c - CH_ZERO;

   always_comb begin
      key_in     = key_ff;
      value_in   = value_ff;
      flag_in    = flag_ff;
      count_in   = count_ff;
      digits_in  = digits_ff;
      colon_in   = colon_ff;
      records_in = records_ff;
      err        = 1'b0;
      rsp_in     = '0;
      rsp_in.string_done = req_chan.last_char;

      if (!error_ff) begin
         if (is_digit) begin
            if (key_ff != CODE_NONE || (kv_mode_ff && colon_ff) ||
                digits_ff >= DIGIT_W'(MAX_DIGITS)) begin
               err = 1'b1;
            end else begin
               count_in  = COUNT_W'(count_ff * COUNT_W'(10)) + COUNT_W'(digit_diff[3:0]);
               digits_in = digits_ff + DIGIT_W'(1);
            end
         end else if (lc != CODE_NONE) begin
            if (key_ff == CODE_NONE) begin
               if (lc == CODE_A) begin
                  err = 1'b1;
               end else begin
                  key_in = lc;
               end
            end else if (kv_mode_ff && value_ff == CODE_NONE) begin
               value_in = lc;
            end else begin
               err = 1'b1;
            end
         end else if (kv_mode_ff && c == CH_COLON) begin
            if (key_ff == CODE_NONE || value_ff == CODE_NONE || colon_ff) begin
               err = 1'b1;
            end else begin
               colon_in = 1'b1;
            end
         end else if (kv_mode_ff && (c == CH_UP_R || c == CH_UP_D)) begin
            if (!colon_ff || flag_ff != FLAG_NONE) begin
               err = 1'b1;
            end else begin
               flag_in = (c == CH_UP_R) ? FLAG_R : FLAG_D;
            end
         end else if (c == CH_BAR) begin
            if (key_ff == CODE_NONE ||
                (kv_mode_ff && (value_ff == CODE_NONE ||
                                (colon_ff && flag_ff == FLAG_NONE))) ||
                records_ff >= REC_W'(MAX_RECORDS)) begin
               err = 1'b1;
            end else begin
               rsp_in.record_valid = 1'b1;
               rsp_in.record_index = records_ff[INDEX_W-1:0];
               rsp_in.repeat_count = (digits_ff != '0) ? count_ff : COUNT_W'(1);
               rsp_in.key_code     = key_ff;
               rsp_in.value_code   = kv_mode_ff ? value_ff : CODE_NONE;
               rsp_in.flag_code    = !kv_mode_ff ? FLAG_NONE :
                                     (flag_ff != FLAG_NONE) ? flag_ff : FLAG_D;
               records_in = records_ff + REC_W'(1);
               key_in     = CODE_NONE;
               value_in   = CODE_NONE;
               flag_in    = FLAG_NONE;
               count_in   = '0;
               digits_in  = '0;
               colon_in   = 1'b0;
            end
         end else begin
            err = 1'b1;
         end
      end

      rsp_in.parse_error = err;
      error_in = error_ff || err;

      // The final character is reported as usual and then the whole string state drops.
      if (req_chan.last_char) begin
         key_in     = CODE_NONE;
         value_in   = CODE_NONE;
         flag_in    = FLAG_NONE;
         count_in   = '0;
         digits_in  = '0;
         colon_in   = 1'b0;
         error_in   = 1'b0;
         records_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kv_mode_ff   <= 1'b1;
         key_ff       <= CODE_NONE;
         value_ff     <= CODE_NONE;
         flag_ff      <= FLAG_NONE;
         count_ff     <= '0;
         digits_ff    <= '0;
         colon_ff     <= 1'b0;
         error_ff     <= 1'b0;
         records_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            kv_mode_ff <= csr_chan.key_value_mode;
         end
         if (accept) begin
            key_ff       <= key_in;
            value_ff     <= value_in;
            flag_ff      <= flag_in;
            count_ff     <= count_in;
            digits_ff    <= digits_in;
            colon_ff     <= colon_in;
            error_ff     <= error_in;
            records_ff   <= records_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.record_valid = rsp_ff.record_valid;
   assign rsp_chan.parse_error  = rsp_ff.parse_error;
   assign rsp_chan.record_index = rsp_ff.record_index;
   assign rsp_chan.repeat_count = rsp_ff.repeat_count;
   assign rsp_chan.key_code     = rsp_ff.key_code;
   assign rsp_chan.value_code   = rsp_ff.value_code;
   assign rsp_chan.flag_code    = rsp_ff.flag_code;
   assign rsp_chan.string_done  = rsp_ff.string_done;

endmodule

`default_nettype wire

[hdl/tdp_checker.sv]
`default_nettype none
`include "type_descriptor_parser_defines.svh"

module tdp_checker import tdp_pkg::*; (
   input wire            clock,
   input wire            reset,
   input wire            rsp_valid,
   input wire            rsp_ready,
   input wire            record_valid,
   input wire            parse_error,
   input wire index_type record_index,
   input wire count_type repeat_count,
   input wire code_type  key_code,
   input wire code_type  value_code,
   input wire flag_type  flag_code,
   input wire            string_done
);

   // A beat cannot both close a record and report the error.
   `TDP_ASSERT_SAME(a_valid_or_error, clock, reset, rsp_valid, !(record_valid && parse_error), "record and error on one beat")

   // Beats without a record carry zero record fields.
   `TDP_ASSERT_SAME(a_empty_fields, clock, reset, rsp_valid && !record_valid, record_index == '0 && repeat_count == '0 && key_code == CODE_NONE && value_code == CODE_NONE && flag_code == FLAG_NONE, "record fields set without a record")

   // An emitted record always has a real key and never the array letter as key, and never flag code 3.
   `TDP_ASSERT_SAME(a_record_key, clock, reset, rsp_valid && record_valid, key_code != CODE_NONE && key_code != CODE_A && key_code != 3'd7 && flag_code != 2'd3, "record with bad key or flag")

   // A stalled result beat holds.
   `TDP_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(record_valid) && $stable(parse_error) && $stable(record_index) && $stable(repeat_count) && $stable(key_code) && $stable(string_done), "result beat changed while stalled")

endmodule

bind type_descriptor_parser tdp_checker u_tdp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .record_valid (rsp_chan.record_valid),
   .parse_error  (rsp_chan.parse_error),
   .record_index (rsp_chan.record_index),
   .repeat_count (rsp_chan.repeat_count),
   .key_code     (rsp_chan.key_code),
   .value_code   (rsp_chan.value_code),
   .flag_code    (rsp_chan.flag_code),
   .string_done  (rsp_chan.string_done)
);

`default_nettype wire
